// ===== src/dsct_pkg.sv =====
// ----------------------------------------------------------------------------
// dsct_pkg
// Shared types, opcodes and BCD digit helpers for the countdown timer.
// ----------------------------------------------------------------------------
package dsct_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int DIGIT_W        = 4;
  localparam int OP_W           = 2;
  localparam int SEL_OUT_W      = 3;
  localparam int DISP_DIGITS    = 4;

  localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
  localparam logic [OP_W-1:0] OP_BLINK = 2'd2;

  localparam logic [DIGIT_W-1:0] BCD_MAX = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            select_press;
    logic            increment_press;
    logic            decrement_press;
    logic            start_press;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]   digit_ones;
    logic [DIGIT_W-1:0]   digit_tens;
    logic [DIGIT_W-1:0]   digit_hundreds;
    logic [DIGIT_W-1:0]   digit_thousands;
    logic                 running;
    logic                 editing;
    logic [SEL_OUT_W-1:0] selected_digit;
    logic                 selected_blank;
  } result_t;

  function automatic logic [DIGIT_W-1:0] bcd_inc(input logic [DIGIT_W-1:0] d);
    return (d >= BCD_MAX) ? '0 : d + DIGIT_W'(1);
  endfunction

  function automatic logic [DIGIT_W-1:0] bcd_dec(input logic [DIGIT_W-1:0] d);
    return (d == '0 || d > BCD_MAX) ? BCD_MAX : d - DIGIT_W'(1);
  endfunction

endpackage

// ===== src/dsct_in_reg.sv =====
// ----------------------------------------------------------------------------
// dsct_in_reg
// Input register: holds one event until the core consumes it.
// ----------------------------------------------------------------------------
module dsct_in_reg
  import dsct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // refill in the same cycle the held item moves on
  assign in_ready  = !valid_r || advance_i;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance_i ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_i;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

// ===== src/dsct_core.sv =====
// ----------------------------------------------------------------------------
// dsct_core
// Timer state and the combinational update applied per event.
// ----------------------------------------------------------------------------
module dsct_core
  import dsct_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int SEL_W   = $clog2(NUM_DIGITS + 1);
  localparam int DISP_N  = (NUM_DIGITS < DISP_DIGITS) ? NUM_DIGITS : DISP_DIGITS;

  logic [DIGIT_W-1:0] digits_r   [NUM_DIGITS];
  logic [DIGIT_W-1:0] digits_nxt [NUM_DIGITS];
  logic               running_r, running_nxt;
  logic               editing_r, editing_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic               blink_r, blink_nxt;

  logic                       stopped;
  logic                       borrow;
  logic                       cur_zero;
  logic                       new_zero;
  logic [DIGIT_W-1:0]         disp [DISP_DIGITS];
  logic [SEL_W+SEL_OUT_W-1:0] sel_ext;

  always_comb begin
    digits_nxt  = digits_r;
    running_nxt = running_r;
    editing_nxt = editing_r;
    sel_nxt     = sel_r;
    blink_nxt   = blink_r;
    stopped     = !running_r;
    borrow      = 1'b1;
    cur_zero    = 1'b1;
    new_zero    = 1'b1;

    case (item_i.opcode)
      OP_POLL: begin
        if (item_i.select_press && stopped) begin
          editing_nxt = 1'b1;
          sel_nxt = (sel_r >= SEL_W'(NUM_DIGITS)) ? SEL_W'(1) : sel_r + SEL_W'(1);
        end
        // buttons act on the position chosen by select in this same poll
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (stopped && editing_nxt && sel_nxt == SEL_W'(i + 1)) begin
            if (item_i.increment_press) digits_nxt[i] = bcd_inc(digits_nxt[i]);
            if (item_i.decrement_press) digits_nxt[i] = bcd_dec(digits_nxt[i]);
          end
        end
        if (item_i.start_press) begin
          running_nxt = !running_r;
          editing_nxt = 1'b0;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (digits_r[i] != '0) cur_zero = 1'b0;
        end
        if (running_r) begin
          if (!cur_zero) begin
            // decimal borrow ripple from the ones digit upward
            for (int i = 0; i < NUM_DIGITS; i++) begin
              if (borrow) begin
                if (digits_r[i] != '0) begin
                  digits_nxt[i] = digits_r[i] - DIGIT_W'(1);
                  borrow        = 1'b0;
                end else begin
                  digits_nxt[i] = BCD_MAX;
                end
              end
            end
          end
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (digits_nxt[i] != '0) new_zero = 1'b0;
          end
          if (new_zero) running_nxt = 1'b0;
        end
      end
      OP_BLINK: begin
        if (editing_r) blink_nxt = !blink_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) digits_r[i] <= '0;
      running_r <= 1'b0;
      editing_r <= 1'b0;
      sel_r     <= '0;
      blink_r   <= 1'b0;
    end else if (advance_i) begin
      digits_r  <= digits_nxt;
      running_r <= running_nxt;
      editing_r <= editing_nxt;
      sel_r     <= sel_nxt;
      blink_r   <= blink_nxt;
    end
  end

  // result reflects the state after the event
  always_comb begin
    for (int i = 0; i < DISP_DIGITS; i++) disp[i] = '0;
    for (int i = 0; i < DISP_N; i++) disp[i] = digits_nxt[i];
    sel_ext = (SEL_W + SEL_OUT_W)'(sel_nxt);
    result_o.digit_ones      = disp[0];
    result_o.digit_tens      = disp[1];
    result_o.digit_hundreds  = disp[2];
    result_o.digit_thousands = disp[3];
    result_o.running         = running_nxt;
    result_o.editing         = editing_nxt;
    result_o.selected_digit  = sel_ext[SEL_OUT_W-1:0];
    result_o.selected_blank  = editing_nxt & blink_nxt;
  end

endmodule

// ===== src/dsct_out_reg.sv =====
// ----------------------------------------------------------------------------
// dsct_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module dsct_out_reg
  import dsct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid_i,
  input  result_t result_i,
  output logic    advance_o,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_o
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign advance_o = item_valid_i && (!valid_r || out_ready);
  assign valid_nxt = advance_o ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_o) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

// ===== src/digit_settable_countdown_timer_unit.sv =====
// ----------------------------------------------------------------------------
// digit_settable_countdown_timer_unit
// Four-digit BCD countdown timer driven by button polls and tick events.
// ----------------------------------------------------------------------------
// Each event (button poll, count tick, blink tick) yields one result with the
// timer state after the event. One event is taken per clock cycle while the
// result register is free or being read; an event is held in the input
// register, then the state registers and the result register load together. The result
// register lets a new event be taken while a finished result is still held.
module digit_settable_countdown_timer_unit
  import dsct_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic                 in_select_press,
  input  logic                 in_increment_press,
  input  logic                 in_decrement_press,
  input  logic                 in_start_press,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIGIT_W-1:0]   out_digit_ones,
  output logic [DIGIT_W-1:0]   out_digit_tens,
  output logic [DIGIT_W-1:0]   out_digit_hundreds,
  output logic [DIGIT_W-1:0]   out_digit_thousands,
  output logic                 out_running,
  output logic                 out_editing,
  output logic [SEL_OUT_W-1:0] out_selected_digit,
  output logic                 out_selected_blank
);

  item_t   item_in, item_q;
  logic    item_valid;
  logic    advance;
  result_t result_c, result_q;

  assign item_in.opcode          = in_opcode;
  assign item_in.select_press    = in_select_press;
  assign item_in.increment_press = in_increment_press;
  assign item_in.decrement_press = in_decrement_press;
  assign item_in.start_press     = in_start_press;

  dsct_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .item_i       (item_in),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item_q)
  );

  dsct_core #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (result_c)
  );

  dsct_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (item_valid),
    .result_i     (result_c),
    .advance_o    (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_o     (result_q)
  );

  assign out_digit_ones      = result_q.digit_ones;
  assign out_digit_tens      = result_q.digit_tens;
  assign out_digit_hundreds  = result_q.digit_hundreds;
  assign out_digit_thousands = result_q.digit_thousands;
  assign out_running         = result_q.running;
  assign out_editing         = result_q.editing;
  assign out_selected_digit  = result_q.selected_digit;
  assign out_selected_blank  = result_q.selected_blank;

endmodule

// ===== src/dsct_checker.sv =====
// ----------------------------------------------------------------------------
// dsct_checker
// Port-level checks for the countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
module dsct_checker
  import dsct_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DIGIT_W-1:0]   out_digit_ones,
  input logic [DIGIT_W-1:0]   out_digit_tens,
  input logic [DIGIT_W-1:0]   out_digit_hundreds,
  input logic [DIGIT_W-1:0]   out_digit_thousands,
  input logic                 out_running,
  input logic                 out_editing,
  input logic                 out_selected_blank
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // editing only starts while stopped, and start ends it
  a_run_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_running && out_editing))
    else $error("running and editing at once");

  a_blank_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_selected_blank |-> out_editing)
    else $error("blanking outside editing");

  a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_ones <= BCD_MAX) && (out_digit_tens <= BCD_MAX) &&
                  (out_digit_hundreds <= BCD_MAX) && (out_digit_thousands <= BCD_MAX))
    else $error("digit outside BCD range");

endmodule

bind digit_settable_countdown_timer_unit dsct_checker u_dsct_checker (.*);
